// ----- rtl/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue: operation codes,
// status codes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  // operation carried by each item
  typedef enum logic [1:0] {
    FN_PUSH_FRONT = 2'd0,
    FN_PUSH_BACK  = 2'd1,
    FN_POP_FRONT  = 2'd2,
    FN_POP_BACK   = 2'd3
  } func_t;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // word width of the stored entries
  localparam int unsigned WORD_W = 32;

  // controller states, one-hot
  typedef enum logic [1:0] {
    S_IDLE  = 2'b01,
    S_FETCH = 2'b10
  } state_t;

endpackage

`default_nettype wire

// ----- rtl/deq_ram.sv -----
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/double_ended_queue.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit words kept as a ring buffer in one RAM.
// Front and back words are cached in registers; a pop refetches the new
// end word from the RAM.
// ----------------------------------------------------------------------------
//
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  command  | start, busy            | func, push_value
//  result   | done (one-cycle pulse) | popped_value, status, front_value,
//           |                        | back_value, entry_count
//
//  For a push, an error and a pop that empties the deque, the result
//  appears in the cycle after the item is taken and the next item
//  can be taken in that same cycle.
//  A pop that leaves words behind waits in the fetch state for the
//  registered read of the RAM; busy is high during the read cycle.
//  Reset clears pointer, count and controller; no clearing pass is needed.
//  The result is shown for exactly one cycle; the receiver cannot stall.
//
`default_nettype none

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [1:0]                        func,
  input  wire logic signed [WORD_W-1:0]          push_value,
  output logic                                   done,
  output logic signed [WORD_W-1:0]               popped_value,
  output logic [1:0]                             status,
  output logic signed [WORD_W-1:0]               front_value,
  output logic signed [WORD_W-1:0]               back_value,
  output logic [$clog2(DEPTH+1)-1:0]             entry_count
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_W  = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C    = CW'(1);
  localparam logic [CW-1:0] TWO_C    = CW'(2);

  // ring index addition, both operands below DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= DEPTH_W) begin
      s = s - DEPTH_W;
    end
    return s[AW-1:0];
  endfunction

  state_t            state, state_next;
  logic [AW-1:0]     head, head_next;
  logic [CW-1:0]     count, count_next;
  logic [WORD_W-1:0] front_word, front_word_next;
  logic [WORD_W-1:0] back_word, back_word_next;
  logic              pend_front, pend_front_next;
  logic              done_next;
  logic [WORD_W-1:0] out_popped_next, out_front_next, out_back_next;
  logic [1:0]        out_status_next;
  logic [CW-1:0]     out_count_next;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic              accept, is_empty, is_full;
  logic [AW-1:0]     head_dec, head_inc, tail_idx, back_prev_idx;
  logic [CW-1:0]     count_m2;

  assign busy     = (state == S_FETCH);
  assign accept   = start && !busy;
  assign is_empty = (count == '0);
  assign is_full  = (count == DEPTH_C);
  assign count_m2 = count - TWO_C;

  // ring positions around the current head
  assign head_dec      = (head == '0) ? LAST_IDX : head - AW'(1);
  assign head_inc      = wrap_add(head, AW'(1));
  assign tail_idx      = wrap_add(head, count[AW-1:0]);
  assign back_prev_idx = wrap_add(head, count_m2[AW-1:0]);

  deq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // operation decode, pointer update and RAM access
  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    front_word_next = front_word;
    back_word_next  = back_word;
    pend_front_next = pend_front;
    done_next       = 1'b0;
    out_popped_next = popped_value;
    out_status_next = status;
    out_front_next  = front_value;
    out_back_next   = back_value;
    out_count_next  = entry_count;
    ram_we          = 1'b0;
    ram_waddr       = head_dec;
    ram_wdata       = push_value;
    ram_re          = 1'b0;
    ram_raddr       = head_inc;

    if (state == S_FETCH) begin
      // refetched end word arrives from the RAM
      if (pend_front) begin
        front_word_next = ram_rdata;
      end else begin
        back_word_next = ram_rdata;
      end
      done_next  = 1'b1;
      state_next = S_IDLE;
    end else if (accept) begin
      out_popped_next = '0;
      out_status_next = ST_OK;
      done_next       = 1'b1;
      case (func_t'(func))
        FN_PUSH_FRONT: begin
          if (is_full) begin
            out_status_next = ST_FULL;
          end else begin
            ram_we          = 1'b1;
            ram_waddr       = head_dec;
            head_next       = head_dec;
            count_next      = count + ONE_C;
            front_word_next = push_value;
            if (is_empty) begin
              back_word_next = push_value;
            end
          end
        end
        FN_PUSH_BACK: begin
          if (is_full) begin
            out_status_next = ST_FULL;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = tail_idx;
            count_next     = count + ONE_C;
            back_word_next = push_value;
            if (is_empty) begin
              front_word_next = push_value;
            end
          end
        end
        FN_POP_FRONT: begin
          if (is_empty) begin
            out_status_next = ST_EMPTY;
          end else begin
            out_popped_next = front_word;
            head_next       = head_inc;
            count_next      = count - ONE_C;
            if (count != ONE_C) begin
              ram_re          = 1'b1;
              ram_raddr       = head_inc;
              pend_front_next = 1'b1;
              done_next       = 1'b0;
              state_next      = S_FETCH;
            end
          end
        end
        default: begin
          if (is_empty) begin
            out_status_next = ST_EMPTY;
          end else begin
            out_popped_next = back_word;
            count_next      = count - ONE_C;
            if (count != ONE_C) begin
              ram_re          = 1'b1;
              ram_raddr       = back_prev_idx;
              pend_front_next = 1'b0;
              done_next       = 1'b0;
              state_next      = S_FETCH;
            end
          end
        end
      endcase
    end

    // end words and count of the result
    if (done_next) begin
      out_front_next = (count_next == '0) ? '1 : front_word_next;
      out_back_next  = (count_next == '0) ? '1 : back_word_next;
      out_count_next = count_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      done  <= done_next;
    end
  end

  // cached end words and result registers
  always_ff @(posedge clk) begin
    front_word   <= front_word_next;
    back_word    <= back_word_next;
    pend_front   <= pend_front_next;
    popped_value <= out_popped_next;
    status       <= out_status_next;
    front_value  <= out_front_next;
    back_value   <= out_back_next;
    entry_count  <= out_count_next;
  end

`ifndef SYNTHESIS
  // a fetch cycle only follows an accepted item
  assert property (@(posedge clk) disable iff (rst)
    busy |-> ($past(start) && !$past(busy)))
    else $error("fetch cycle without an accepted pop");

  // every result comes from an accepted item or a fetch
  assert property (@(posedge clk) disable iff (rst)
    done |-> (($past(start) && !$past(busy)) || $past(busy)))
    else $error("result without a source item");

  // a push into a deque with room grows the count by one
  assert property (@(posedge clk) disable iff (rst)
    (accept && !is_full &&
     (func == FN_PUSH_FRONT || func == FN_PUSH_BACK))
    |=> (count == $past(count) + ONE_C))
    else $error("push did not grow the count");
`endif

endmodule

`default_nettype wire

// ----- tb/deq_checker.sv -----
// ----------------------------------------------------------------------------
// deq_checker
// Watches the command and result channels of the double-ended queue, keeps
// its own ring-buffer copy of the deque contents, and compares every result
// item field by field against the prediction made when the item was taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module deq_checker
  import deq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic                              busy,
  input  logic [1:0]                        func,
  input  logic signed [WORD_W-1:0]          push_value,
  input  logic                              done,
  input  logic signed [WORD_W-1:0]          popped_value,
  input  logic [1:0]                        status,
  input  logic signed [WORD_W-1:0]          front_value,
  input  logic signed [WORD_W-1:0]          back_value,
  input  logic [$clog2(DEPTH+1)-1:0]        entry_count,
  output int                                error_count,
  output int                                pending,
  output int                                results_seen,
  output int                                full_hits,
  output int                                empty_hits
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH+1);

  typedef struct packed {
    logic signed [WORD_W-1:0] popped;
    logic [1:0]               stat;
    logic signed [WORD_W-1:0] front;
    logic signed [WORD_W-1:0] back;
    logic [CNT_W-1:0]         count;
  } deq_result_t;

  // shadow copy of the deque
  logic signed [WORD_W-1:0] deque_slots [DEPTH];
  logic [IDX_W-1:0]         front_idx;
  logic [CNT_W-1:0]         fill_level;

  deq_result_t pending_results [$];
  int          errors;
  int          checked;
  int          full_cnt;
  int          empty_cnt;

  initial begin
    errors    = 0;
    checked   = 0;
    full_cnt  = 0;
    empty_cnt = 0;
    front_idx  = '0;
    fill_level = '0;
    error_count  = 0;
    pending      = 0;
    results_seen = 0;
    full_hits    = 0;
    empty_hits   = 0;
  end

  // apply one operation to the shadow deque and work out its result
  task automatic predict_operation(input logic [1:0] op,
                                   input logic signed [WORD_W-1:0] word,
                                   output deq_result_t res);
    logic [IDX_W-1:0] tail_idx;
    res.popped = '0;
    res.stat   = ST_OK;
    res.front  = '1;
    res.back   = '1;
    tail_idx   = front_idx + fill_level[IDX_W-1:0] - 1'b1;
    case (func_t'(op))
      FN_PUSH_FRONT: begin
        if (fill_level == CNT_W'(DEPTH)) begin
          res.stat = ST_FULL;
        end else begin
          front_idx = front_idx - 1'b1;
          deque_slots[front_idx] = word;
          fill_level = fill_level + 1'b1;
        end
      end
      FN_PUSH_BACK: begin
        if (fill_level == CNT_W'(DEPTH)) begin
          res.stat = ST_FULL;
        end else begin
          deque_slots[IDX_W'(front_idx + fill_level[IDX_W-1:0])] = word;
          fill_level = fill_level + 1'b1;
        end
      end
      FN_POP_FRONT: begin
        if (fill_level == '0) begin
          res.stat = ST_EMPTY;
        end else begin
          res.popped = deque_slots[front_idx];
          front_idx = front_idx + 1'b1;
          fill_level = fill_level - 1'b1;
        end
      end
      default: begin
        if (fill_level == '0) begin
          res.stat = ST_EMPTY;
        end else begin
          res.popped = deque_slots[tail_idx];
          fill_level = fill_level - 1'b1;
        end
      end
    endcase
    // ends of the deque after the operation, all ones when empty
    if (fill_level != '0) begin
      tail_idx  = front_idx + fill_level[IDX_W-1:0] - 1'b1;
      res.front = deque_slots[front_idx];
      res.back  = deque_slots[tail_idx];
    end
    res.count = fill_level;
  endtask

  task automatic compare_field(input string label, input logic [WORD_W-1:0] want,
                               input logic [WORD_W-1:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t deq_checker: %s mismatch, expected %h, actual %h",
               $time, label, want, got);
    end
  endtask

  // result check first, then capture of a newly taken item
  always @(posedge clk) begin
    deq_result_t want;
    deq_result_t fresh;
    if (rst) begin
      front_idx  = '0;
      fill_level = '0;
      pending_results.delete();
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t deq_checker: result item with nothing expected, actual status %h",
                   $time, status);
        end else begin
          // oldest expected item sits at index 0
          want = pending_results[0];
          pending_results.delete(0);
          compare_field("popped_value", want.popped, popped_value);
          compare_field("status", WORD_W'(want.stat), WORD_W'(status));
          compare_field("front_value", want.front, front_value);
          compare_field("back_value", want.back, back_value);
          compare_field("entry_count", WORD_W'(want.count), WORD_W'(entry_count));
          checked++;
          if (want.stat == ST_FULL) full_cnt++;
          if (want.stat == ST_EMPTY) empty_cnt++;
        end
      end
      if (start && !busy) begin
        predict_operation(func, push_value, fresh);
        pending_results.insert(pending_results.size(), fresh);
      end
    end
    error_count  <= errors;
    pending      <= pending_results.size();
    results_seen <= checked;
    full_hits    <= full_cnt;
    empty_hits   <= empty_cnt;
  end

  // anything still expected is visible to the top through pending, which it waits on to drain

endmodule

// ----- tb/double_ended_queue_tb.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_tb
// Drives push and pop items into the double-ended queue with random gaps,
// starting with a directed pass over the empty, full and extreme-word cases,
// then biased random phases that swing the deque between empty and full.
// A separate checker predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int unsigned DEPTH = 16;
  localparam int CNT_W          = $clog2(DEPTH+1);
  localparam int RANDOM_ITEMS   = 640;
  localparam int SEGMENT_LEN    = 40;
  localparam int MAX_GAP        = 18;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic [1:0]               func = FN_PUSH_FRONT;
  logic signed [WORD_W-1:0] push_value = '0;
  logic                     busy;
  logic                     done;
  logic signed [WORD_W-1:0] popped_value;
  logic [1:0]               status;
  logic signed [WORD_W-1:0] front_value;
  logic signed [WORD_W-1:0] back_value;
  logic [CNT_W-1:0]         entry_count;

  int error_count;
  int pending;
  int results_seen;
  int full_hits;
  int empty_hits;
  int idle_cycles = 0;
  int items_sent = 0;
  bit burst_mode = 1'b0;

  always #4 clk = ~clk;

  double_ended_queue #(.DEPTH(DEPTH)) i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .push_value   (push_value),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .front_value  (front_value),
    .back_value   (back_value),
    .entry_count  (entry_count)
  );

  deq_checker #(.DEPTH(DEPTH)) i_checker (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .push_value   (push_value),
    .done         (done),
    .popped_value (popped_value),
    .status       (status),
    .front_value  (front_value),
    .back_value   (back_value),
    .entry_count  (entry_count),
    .error_count  (error_count),
    .pending      (pending),
    .results_seen (results_seen),
    .full_hits    (full_hits),
    .empty_hits   (empty_hits)
  );

  // watchdog on cycles where neither channel moves an item
  always @(posedge clk) begin
    if (!rst) begin
      if ((start && !busy) || done) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t no progress for %0d cycles", $time, idle_cycles);
        $display("double_ended_queue_tb: done, errors");
        $finish;
      end
    end
  end

  // extremes show up often so the full-scale words get stored and popped
  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // present one item, hold it until taken, then idle for the given gap
  task automatic send_item(input func_t op, input logic [WORD_W-1:0] word, input int gap);
    start      <= 1'b1;
    func       <= op;
    push_value <= word;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (gap > 0) begin
      start      <= 1'b0;
      func       <= 2'($urandom_range(0, 3));
      push_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic int draw_gap();
    if (burst_mode) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  initial begin
    int    n;
    int    push_pct;
    func_t op;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // pops on the empty deque
    send_item(FN_POP_FRONT, random_word(), $urandom_range(0, 3));
    send_item(FN_POP_BACK, random_word(), $urandom_range(0, 3));

    // fill from both ends with extreme words first
    send_item(FN_PUSH_FRONT, 32'h7fff_ffff, $urandom_range(0, 3));
    send_item(FN_PUSH_BACK, 32'h8000_0000, $urandom_range(0, 3));
    send_item(FN_PUSH_FRONT, 32'h0000_0000, $urandom_range(0, 3));
    send_item(FN_PUSH_BACK, 32'hffff_ffff, $urandom_range(0, 3));
    send_item(FN_PUSH_FRONT, 32'h5555_5555, $urandom_range(0, 3));
    send_item(FN_PUSH_BACK, 32'haaaa_aaaa, $urandom_range(0, 3));
    for (n = 0; n < DEPTH - 6; n++) begin
      send_item((n % 2) ? FN_PUSH_BACK : FN_PUSH_FRONT, random_word(), 0);
    end

    // pushes on the full deque
    send_item(FN_PUSH_FRONT, random_word(), $urandom_range(0, 3));
    send_item(FN_PUSH_BACK, random_word(), $urandom_range(0, 3));

    // pops from both ends, back to back and spaced
    send_item(FN_POP_FRONT, random_word(), 0);
    send_item(FN_POP_BACK, random_word(), 0);
    send_item(FN_POP_FRONT, random_word(), 2);
    send_item(FN_POP_BACK, random_word(), 1);

    // random phases, each with its own push bias and idling style
    push_pct = 50;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % SEGMENT_LEN == 0) begin
        case ($urandom_range(0, 4))
          0:       push_pct = 5;
          1:       push_pct = 20;
          2:       push_pct = 50;
          3:       push_pct = 80;
          default: push_pct = 95;
        endcase
        burst_mode = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 99) < push_pct) begin
        op = $urandom_range(0, 1) ? FN_PUSH_BACK : FN_PUSH_FRONT;
      end else begin
        op = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
      end
      send_item(op, random_word(), draw_gap());
    end

    // drain the outstanding results, then a short settle
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d items, %0d result items compared", items_sent, results_seen);
    $display("push-on-full hit %0d times, pop-on-empty hit %0d times", full_hits, empty_hits);
    if (error_count == 0) begin
      $display("double_ended_queue_tb: done, clean");
    end else begin
      $display("double_ended_queue_tb: done, errors");
    end
    $finish;
  end

endmodule
